[rtl/drpe_pkg.sv]
// shared types and constants of the diagonal region pixel effects block
package drpe_pkg;

  localparam int HIST_BINS_DEF = 8;
  localparam int MAX_DIM_DEF = 4096;
  localparam int FRAME_COLS_RESET = 512;
  localparam int QUEUE_DEPTH = 2;

  localparam int CNT_W = 25;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam int BIN_IDX_W = 3;
  localparam int PIX_W = 8;

  // x/3 as (x * 683) >> 11, exact for x below 1024
  localparam int RECIP3 = 683;
  localparam int RECIP_SHIFT = 11;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BINS = 1'b1;

  typedef enum logic [1:0] {
    REG_RIGHT  = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_LEFT   = 2'd2,
    REG_TOP    = 2'd3
  } region_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    region_t          region;
    logic             frame_end;
  } pix_item_t;

endpackage

[rtl/drpe_front.sv]
// front end: accepts pixels, finds lightness bin and region, applies the effect
module drpe_front
  import drpe_pkg::*;
#(
  parameter int HIST_BINS = HIST_BINS_DEF,
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int COORD_W = $clog2(MAX_DIM),
  localparam int COLS_W = COORD_W + 1,
  localparam int BIN_W = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_pixel_col,
  input  logic [COORD_W-1:0] in_pixel_row,
  input  logic [PIX_W-1:0]   in_blue,
  input  logic [PIX_W-1:0]   in_green,
  input  logic [PIX_W-1:0]   in_red,
  input  logic               in_frame_end,
  input  logic [COLS_W-1:0]  frame_cols,
  input  logic               q_full,
  output logic               q_push,
  output pix_item_t          q_item,
  output logic [BIN_W-1:0]   q_bin
);

  localparam int BIN_WIDTH = 256 / HIST_BINS;
  localparam int BOTTOM_ADD = 80;
  localparam int TOP_SUB = 180;
  localparam int TOP_LOW = 90;
  localparam int TOP_HIGH = 218;

  typedef logic [BIN_W-1:0] bin_lut_t [256];

  function automatic bin_lut_t build_lut();
    bin_lut_t lut;
    int       v;
    for (int i = 0; i < 256; i++) begin
      v = i / BIN_WIDTH;
      if (v > HIST_BINS - 1) v = HIST_BINS - 1;
      lut[i] = BIN_W'(v);
    end
    return lut;
  endfunction

  localparam bin_lut_t BIN_LUT = build_lut();

  function automatic logic [PIX_W-1:0] fx_bottom(input logic [PIX_W-1:0] p);
    logic [PIX_W:0] t;
    t = {1'b0, p} + (PIX_W+1)'(BOTTOM_ADD);
    return t[PIX_W] ? {PIX_W{1'b1}} : t[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] fx_top(input logic [PIX_W-1:0] p);
    logic [PIX_W:0] t;
    t = {p, 1'b0} - (PIX_W+1)'(TOP_SUB);
    if (p < PIX_W'(TOP_LOW)) return '0;
    else if (p >= PIX_W'(TOP_HIGH)) return {PIX_W{1'b1}};
    else return t[PIX_W-1:0];
  endfunction

  logic [9:0]          sum_bgr;
  logic [19:0]         light_prod;
  logic [PIX_W-1:0]    lightness;
  logic signed [10:0]  left_diff;
  logic [8:0]          left_inc;
  logic [19:0]         left_prod;
  logic [PIX_W-1:0]    left_val;
  logic [COLS_W-1:0]   diag_sum;
  logic                past_anti;
  logic                right_of_diag;

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;

  assign sum_bgr = 10'(in_blue) + 10'(in_green) + 10'(in_red);
  assign light_prod = 20'(sum_bgr) * 20'(RECIP3);
  assign lightness = light_prod[RECIP_SHIFT +: PIX_W];
  assign q_bin = BIN_LUT[lightness];

  // 3r - s = 2r - b - g, rounded third of it
  assign left_diff = $signed({2'b00, in_red, 1'b0}) - $signed({3'b000, in_blue})
                     - $signed({3'b000, in_green});
  assign left_inc = left_diff[8:0] + 9'd1;
  assign left_prod = 20'(left_inc) * 20'(RECIP3);
  assign left_val = left_diff[10] ? '0 : left_prod[RECIP_SHIFT +: PIX_W];

  // w - y < x  is  w < x + y
  assign diag_sum = COLS_W'(in_pixel_col) + COLS_W'(in_pixel_row);
  assign past_anti = frame_cols < diag_sum;
  assign right_of_diag = in_pixel_col >= in_pixel_row;

  always_comb begin
    q_item.frame_end = in_frame_end;
    if (right_of_diag && past_anti) begin
      q_item.region = REG_RIGHT;
      q_item.blue = in_blue;
      q_item.green = in_green;
      q_item.red = in_red;
    end else if (past_anti) begin
      q_item.region = REG_BOTTOM;
      q_item.blue = fx_bottom(in_blue);
      q_item.green = fx_bottom(in_green);
      q_item.red = fx_bottom(in_red);
    end else if (!right_of_diag) begin
      q_item.region = REG_LEFT;
      q_item.blue = left_val;
      q_item.green = left_val;
      q_item.red = left_val;
    end else begin
      q_item.region = REG_TOP;
      q_item.blue = fx_top(in_blue);
      q_item.green = fx_top(in_green);
      q_item.red = fx_top(in_red);
    end
  end

endmodule

[rtl/drpe_fifo.sv]
// short queue between front end and histogram back end
module drpe_fifo
  import drpe_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_QW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign empty = count_r == '0;
  assign full = count_r == CNT_QW'(DEPTH);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_QW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

[rtl/drpe_back.sv]
// back end: histogram update, frame end readout and output register
module drpe_back
  import drpe_pkg::*;
#(
  parameter int HIST_BINS = HIST_BINS_DEF,
  localparam int BIN_W = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  pix_item_t             q_item,
  input  logic [BIN_W-1:0]      q_bin,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_result_kind,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_red,
  output logic [1:0]            out_region,
  output logic [BIN_IDX_W-1:0]  out_bin_index,
  output logic [CNT_W-1:0]      out_bin_count,
  output logic [CNT_W-1:0]      out_pixel_total,
  output logic                  out_last_of_run
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_DRAIN
  } state_t;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);

  state_t state_r, state_nxt;
  logic [BIN_W-1:0] rd_idx_r, rd_idx_nxt;

  // bin counts; an entry without its valid bit reads as zero
  logic [CNT_W-1:0]     bin_mem [HIST_BINS];
  logic [HIST_BINS-1:0] bin_vld_r;
  logic [CNT_W-1:0]     rd_data_r;
  logic                 rd_vld_r;
  logic [BIN_W-1:0]     rd_addr;

  logic             fwd_vld_r;
  logic [BIN_W-1:0] fwd_addr_r;
  logic [CNT_W-1:0] fwd_val_r;
  logic [CNT_W-1:0] pix_cnt_r;

  logic             s1_vld_r;
  logic             s1_kind_r;
  pix_item_t        s1_item_r;
  logic [BIN_W-1:0] s1_addr_r;
  logic             s1_last_r;

  logic                 out_vld_r;
  logic                 out_kind_r;
  logic [PIX_W-1:0]     out_blue_r;
  logic [PIX_W-1:0]     out_green_r;
  logic [PIX_W-1:0]     out_red_r;
  logic [1:0]           out_region_r;
  logic [BIN_IDX_W-1:0] out_bin_index_r;
  logic [CNT_W-1:0]     out_bin_count_r;
  logic [CNT_W-1:0]     out_pixel_total_r;
  logic                 out_last_r;

  logic             out_free;
  logic             adv;
  logic             feed_pix;
  logic             feed_rep;
  logic             wr_en;
  logic             clr;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] pix_cnt_inc;
  logic [7:0]       s1_addr_ext;

  assign out_free = !out_vld_r || out_ready;
  assign adv = !s1_vld_r || out_free;
  assign feed_pix = adv && (state_r == ST_RUN) && !q_empty;
  assign feed_rep = adv && (state_r == ST_READ);
  assign q_pop = feed_pix;
  assign clr = adv && (state_r == ST_DRAIN);

  // a stalled stage re-reads its own bin so the registered data stays current
  assign rd_addr = !adv ? s1_addr_r : ((state_r == ST_READ) ? rd_idx_r : q_bin);

  // bypass the write made at the previous edge
  assign cnt_cur = (fwd_vld_r && fwd_addr_r == s1_addr_r) ? fwd_val_r :
                   (rd_vld_r ? rd_data_r : '0);
  assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign pix_cnt_inc = (pix_cnt_r == COUNT_MAX) ? pix_cnt_r : pix_cnt_r + 1'b1;
  assign wr_en = adv && s1_vld_r && (s1_kind_r == KIND_PIXEL);
  assign s1_addr_ext = 8'(s1_addr_r);

  always_comb begin
    state_nxt = state_r;
    rd_idx_nxt = rd_idx_r;
    unique case (state_r)
      ST_RUN: begin
        if (feed_pix && q_item.frame_end) begin
          state_nxt = ST_READ;
          rd_idx_nxt = '0;
        end
      end
      ST_READ: begin
        if (feed_rep) begin
          if (rd_idx_r == LAST_BIN) state_nxt = ST_DRAIN;
          else rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (adv) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) bin_mem[s1_addr_r] <= cnt_inc;
    rd_data_r <= bin_mem[rd_addr];
    rd_vld_r <= bin_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      rd_idx_r <= '0;
      bin_vld_r <= '0;
      pix_cnt_r <= '0;
      fwd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      fwd_vld_r <= wr_en;
      if (clr) begin
        bin_vld_r <= '0;
        pix_cnt_r <= '0;
      end else if (wr_en) begin
        bin_vld_r[s1_addr_r] <= 1'b1;
        pix_cnt_r <= pix_cnt_inc;
      end
      if (adv) s1_vld_r <= feed_pix || feed_rep;
      if (out_free) out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_val_r <= cnt_inc;
    if (adv) begin
      s1_kind_r <= feed_rep ? KIND_BINS : KIND_PIXEL;
      s1_item_r <= q_item;
      s1_addr_r <= feed_rep ? rd_idx_r : q_bin;
      s1_last_r <= feed_rep && (rd_idx_r == LAST_BIN);
    end
    if (out_free) begin
      out_kind_r <= s1_kind_r;
      if (s1_kind_r == KIND_PIXEL) begin
        out_blue_r <= s1_item_r.blue;
        out_green_r <= s1_item_r.green;
        out_red_r <= s1_item_r.red;
        out_region_r <= s1_item_r.region;
        out_bin_index_r <= '0;
        out_bin_count_r <= '0;
        out_pixel_total_r <= '0;
        out_last_r <= !s1_item_r.frame_end;
      end else begin
        out_blue_r <= '0;
        out_green_r <= '0;
        out_red_r <= '0;
        out_region_r <= REG_RIGHT;
        out_bin_index_r <= s1_addr_ext[BIN_IDX_W-1:0];
        out_bin_count_r <= cnt_cur;
        out_pixel_total_r <= pix_cnt_r;
        out_last_r <= s1_last_r;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_result_kind = out_kind_r;
  assign out_blue = out_blue_r;
  assign out_green = out_green_r;
  assign out_red = out_red_r;
  assign out_region = out_region_r;
  assign out_bin_index = out_bin_index_r;
  assign out_bin_count = out_bin_count_r;
  assign out_pixel_total = out_pixel_total_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_clear_zeroes_total: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> pix_cnt_r == '0) else $error("pixel total not cleared after readout");
  a_last_report_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_kind_r == KIND_BINS && s1_last_r) |-> state_r == ST_DRAIN)
    else $error("last bin report staged outside drain");
  a_no_pop_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_DRAIN) |-> !q_pop)
    else $error("pixel taken during readout");
  a_no_update_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_kind_r == KIND_BINS) |-> !wr_en)
    else $error("bin written by a report beat");
`endif

endmodule

[rtl/diagonal_region_pixel_effects_hist.sv]
// Diagonal region pixel effects with lightness histogram. Each accepted pixel
// gives one modified pixel; a pixel marked as frame end gives the modified
// pixel followed by one report per histogram bin (HIST_BINS reports), after
// which the bins and the pixel total restart from zero. Pixels are taken one
// per clock while out_ready holds and no readout runs, each through the queue,
// the s1 stage and the output register. The readout sends one report per
// clock while out_ready holds, then clears the bins in a drain state; the bin
// counts live in a registered-read memory and are updated read-modify-write.
// frame_cols may be rewritten at any time the block is idle and resets to 512.
module diagonal_region_pixel_effects_hist
  import drpe_pkg::*;
#(
  parameter int HIST_BINS = HIST_BINS_DEF,
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int COORD_W = $clog2(MAX_DIM),
  localparam int COLS_W = COORD_W + 1,
  localparam int BIN_W = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [COLS_W-1:0]    cfg_frame_cols,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_pixel_col,
  input  logic [COORD_W-1:0]   in_pixel_row,
  input  logic [PIX_W-1:0]     in_blue,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_red,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic [PIX_W-1:0]     out_blue,
  output logic [PIX_W-1:0]     out_green,
  output logic [PIX_W-1:0]     out_red,
  output logic [1:0]           out_region,
  output logic [BIN_IDX_W-1:0] out_bin_index,
  output logic [CNT_W-1:0]     out_bin_count,
  output logic [CNT_W-1:0]     out_pixel_total,
  output logic                 out_last_of_run
);

  localparam int ITEM_W = $bits(pix_item_t);
  localparam int ENTRY_W = ITEM_W + BIN_W;

  logic [COLS_W-1:0]  frame_cols_r;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  pix_item_t          f_item;
  logic [BIN_W-1:0]   f_bin;
  logic [ENTRY_W-1:0] q_rdata;
  pix_item_t          b_item;
  logic [BIN_W-1:0]   b_bin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r <= COLS_W'(FRAME_COLS_RESET);
    end else if (cfg_valid) begin
      frame_cols_r <= cfg_frame_cols;
    end
  end

  drpe_front #(
    .HIST_BINS(HIST_BINS),
    .MAX_DIM  (MAX_DIM)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel_col(in_pixel_col),
    .in_pixel_row(in_pixel_row),
    .in_blue     (in_blue),
    .in_green    (in_green),
    .in_red      (in_red),
    .in_frame_end(in_frame_end),
    .frame_cols  (frame_cols_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (f_item),
    .q_bin       (f_bin)
  );

  drpe_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({f_bin, f_item}),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty),
    .full (q_full)
  );

  assign b_item = pix_item_t'(q_rdata[ITEM_W-1:0]);
  assign b_bin = q_rdata[ENTRY_W-1 -: BIN_W];

  drpe_back #(
    .HIST_BINS(HIST_BINS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (b_item),
    .q_bin          (b_bin),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_region     (out_region),
    .out_bin_index  (out_bin_index),
    .out_bin_count  (out_bin_count),
    .out_pixel_total(out_pixel_total),
    .out_last_of_run(out_last_of_run)
  );

endmodule
